### src/sdau_pkg.sv
// Package of shared constants, types and digit helpers for the signed decimal arithmetic unit.
package sdau_pkg;
  localparam int Digits = 16;
  localparam int DigW = $clog2(Digits + 1);
  localparam int BusW = 64;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;

  localparam logic [1:0] CMP_EQ = 2'd0;
  localparam logic [1:0] CMP_AGT = 2'd1;
  localparam logic [1:0] CMP_BGT = 2'd2;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_CMP  = 7'b0000010,
    ST_ADD  = 7'b0000100,
    ST_MUL  = 7'b0001000,
    ST_DIVS = 7'b0010000,
    ST_DIVQ = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  typedef struct packed {
    logic       sub;
    logic [3:0] a;
    logic [3:0] b;
    logic       cin;
  } dig_op_t;

  typedef struct packed {
    logic [3:0] d;
    logic       cout;
  } dig_res_t;

  // Nonzero nibble above nine counts as zero.
  function automatic logic [3:0] clean(input logic [3:0] n);
    clean = (n > 4'd9) ? 4'd0 : n;
  endfunction
endpackage

### src/sdau_digit_alu.sv
// One BCD digit adder/subtractor with carry or borrow.
module sdau_digit_alu (
  input  sdau_pkg::dig_op_t  op,
  output sdau_pkg::dig_res_t res
);
  logic [4:0] s;
  always_comb begin
    if (op.sub) begin
      s = {1'b0, op.a} - {1'b0, op.b} - {4'd0, op.cin};
      if (s[4]) begin
        res.d = 4'(s[3:0] + 4'd10);
        res.cout = 1'b1;
      end else begin
        res.d = s[3:0];
        res.cout = 1'b0;
      end
    end else begin
      s = {1'b0, op.a} + {1'b0, op.b} + {4'd0, op.cin};
      if (s > 5'd9) begin
        res.d = 4'(s - 5'd10);
        res.cout = 1'b1;
      end else begin
        res.d = s[3:0];
        res.cout = 1'b0;
      end
    end
  end
endmodule

### src/signed_decimal_arithmetic_unit.sv
// Top level of the signed decimal arithmetic unit.
// The unit takes one transaction at a time: it is accepted when start is high
// and busy is low, and its result appears for exactly one cycle with done high.
// The receiver cannot stall the result. All arithmetic passes through one
// BCD digit adder that handles one digit per cycle, with operands rotating
// through digit shift registers. Every request starts with a magnitude compare
// pass, after which compare and the unused request codes finish, and add and
// subtract run a digit-serial add or subtract. Multiply then, per multiplier
// digit, adds the multiplicand digit-serially as many times as the digit's
// value and then shifts it up one digit. Divide then, per quotient digit,
// brings down a dividend digit and runs digit-serial trial subtractions
// (quotient digit plus one trials), as restoring repeated subtraction one
// quotient digit at a time. A zero divisor finishes right after the compare
// pass.
module signed_decimal_arithmetic_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [63:0] in_a_digits,
  input  logic        in_a_negative,
  input  logic [63:0] in_b_digits,
  input  logic        in_b_negative,
  output logic        done,
  output logic [63:0] out_result_digits,
  output logic        out_result_negative,
  output logic [1:0]  out_compare_result,
  output logic        out_divide_by_zero,
  output logic        out_overflow
);
  localparam int D = sdau_pkg::Digits;
  localparam int MW = 4 * D;
  localparam int DW = sdau_pkg::DigW;

  sdau_pkg::state_t state_r, state_nxt;

  // Operand and accumulator digit registers; rotation moves the low digit out.
  logic [MW-1:0] a_r, a_nxt, b_r, b_nxt, acc_r, acc_nxt, q_r, q_nxt;
  logic [MW+3:0] rem_r, rem_nxt;          // divide remainder with one spare digit
  logic [MW+3:0] tmp_r, tmp_nxt;          // trial difference
  logic [2:0]    op_r, op_nxt;
  logic          na_r, na_nxt, nb_r, nb_nxt;
  logic          carry_r, carry_nxt;
  logic [1:0]    mcmp_r, mcmp_nxt;       // magnitude compare, most significant wins
  logic [DW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] dig_r, dig_nxt;         // outer digit counter
  logic [3:0]    rep_r, rep_nxt;         // repetitions left or quotient digit
  logic          ovf_r, ovf_nxt;
  logic          dz_r, dz_nxt;
  logic [MW-1:0] res_r, res_nxt;
  logic          rneg_r, rneg_nxt;
  logic [1:0]    rcmp_r, rcmp_nxt;
  logic          rdz_r, rdz_nxt, rovf_r, rovf_nxt, done_r, done_nxt;

  sdau_pkg::dig_op_t  alu_op;
  sdau_pkg::dig_res_t alu_res;
  sdau_digit_alu u_alu (.op(alu_op), .res(alu_res));

  logic [MW-1:0] ca, cb;
  always_comb begin
    for (int k = 0; k < D; k++) begin
      ca[4*k +: 4] = sdau_pkg::clean(in_a_digits[4*k +: 4]);
      cb[4*k +: 4] = sdau_pkg::clean(in_b_digits[4*k +: 4]);
    end
  end

  assign busy = !state_r[0];
  assign done = done_r;
  always_comb begin
    out_result_digits = '0;
    out_result_digits[MW-1:0] = res_r;
  end
  assign out_result_negative = rneg_r;
  assign out_compare_result = rcmp_r;
  assign out_divide_by_zero = rdz_r;
  assign out_overflow = rovf_r;

  logic a_zero, b_zero, big_a;
  assign a_zero = (a_r == '0);
  assign b_zero = (b_r == '0);
  assign big_a = (mcmp_r != sdau_pkg::CMP_BGT);

  always_comb begin
    state_nxt = state_r;
    a_nxt = a_r; b_nxt = b_r; acc_nxt = acc_r; q_nxt = q_r;
    rem_nxt = rem_r; tmp_nxt = tmp_r;
    op_nxt = op_r; na_nxt = na_r; nb_nxt = nb_r;
    carry_nxt = carry_r; mcmp_nxt = mcmp_r; cnt_nxt = cnt_r; dig_nxt = dig_r;
    rep_nxt = rep_r; ovf_nxt = ovf_r; dz_nxt = dz_r;
    res_nxt = res_r; rneg_nxt = rneg_r; rcmp_nxt = rcmp_r;
    rdz_nxt = rdz_r; rovf_nxt = rovf_r;
    done_nxt = 1'b0;
    alu_op = '0;

    case (state_r)
      sdau_pkg::ST_IDLE: begin
        if (start) begin
          a_nxt = ca; b_nxt = cb;
          op_nxt = in_req_type;
          na_nxt = in_a_negative; nb_nxt = in_b_negative;
          mcmp_nxt = sdau_pkg::CMP_EQ;
          cnt_nxt = '0; dig_nxt = '0; carry_nxt = 1'b0;
          acc_nxt = '0; q_nxt = '0; rem_nxt = '0;
          ovf_nxt = 1'b0; dz_nxt = 1'b0;
          state_nxt = sdau_pkg::ST_CMP;
        end
      end
      // Digit-serial magnitude compare; also normalizes signs on the first cycle.
      sdau_pkg::ST_CMP: begin
        if (cnt_r == '0) begin
          na_nxt = na_r && !a_zero;
          if (op_r == sdau_pkg::OP_SUB) nb_nxt = !nb_r && !b_zero;
          else nb_nxt = nb_r && !b_zero;
          if (op_r == sdau_pkg::OP_DIV && b_zero) dz_nxt = 1'b1;
        end
        if (a_r[3:0] > b_r[3:0]) mcmp_nxt = sdau_pkg::CMP_AGT;
        else if (a_r[3:0] < b_r[3:0]) mcmp_nxt = sdau_pkg::CMP_BGT;
        a_nxt = {a_r[3:0], a_r[MW-1:4]};
        b_nxt = {b_r[3:0], b_r[MW-1:4]};
        cnt_nxt = DW'(cnt_r + 1'b1);
        if (cnt_r == DW'(D - 1)) begin
          cnt_nxt = '0;
          case (op_r)
            sdau_pkg::OP_ADD, sdau_pkg::OP_SUB: state_nxt = sdau_pkg::ST_ADD;
            sdau_pkg::OP_MUL: begin
              // One rotation short of a full turn, the lowest multiplier
              // digit sits in the second nibble.
              rep_nxt = b_r[7:4];
              state_nxt = sdau_pkg::ST_MUL;
            end
            sdau_pkg::OP_DIV: begin
              if (dz_r || (op_r == sdau_pkg::OP_DIV && b_zero)) begin
                dz_nxt = 1'b1;
                state_nxt = sdau_pkg::ST_DONE;
              end else begin
                rem_nxt = '0;
                state_nxt = sdau_pkg::ST_DIVS;
              end
            end
            default: state_nxt = sdau_pkg::ST_DONE;
          endcase
        end
      end
      // Add or subtract one digit a cycle; larger magnitude is the minuend.
      sdau_pkg::ST_ADD: begin
        alu_op.sub = (na_r != nb_r);
        alu_op.a = (alu_op.sub && !big_a) ? b_r[3:0] : a_r[3:0];
        alu_op.b = (alu_op.sub && !big_a) ? a_r[3:0] : b_r[3:0];
        alu_op.cin = carry_r;
        carry_nxt = alu_res.cout;
        acc_nxt = {alu_res.d, acc_r[MW-1:4]};
        a_nxt = {a_r[3:0], a_r[MW-1:4]};
        b_nxt = {b_r[3:0], b_r[MW-1:4]};
        cnt_nxt = DW'(cnt_r + 1'b1);
        if (cnt_r == DW'(D - 1)) begin
          if (!alu_op.sub) ovf_nxt = alu_res.cout;
          state_nxt = sdau_pkg::ST_DONE;
        end
      end
      // Multiply: add the shifted multiplicand rep times per multiplier digit.
      // The multiplicand a_r rotates through one full pass per addition;
      // acc_r holds the product's low digits, ovf_r catches any lost digit.
      sdau_pkg::ST_MUL: begin
        if (rep_r == 4'd0) begin
          // Next multiplier digit: shift multiplicand up one digit.
          if (a_r[MW-1:MW-4] != 4'd0 && b_r[MW-1:4] != '0) ovf_nxt = 1'b1;
          a_nxt = {a_r[MW-5:0], 4'd0};
          b_nxt = {4'd0, b_r[MW-1:4]};
          rep_nxt = b_r[7:4];
          dig_nxt = DW'(dig_r + 1'b1);
          if (dig_r == DW'(D - 1)) state_nxt = sdau_pkg::ST_DONE;
        end else begin
          alu_op.sub = 1'b0;
          alu_op.a = acc_r[3:0];
          alu_op.b = a_r[3:0];
          alu_op.cin = carry_r;
          acc_nxt = {alu_res.d, acc_r[MW-1:4]};
          a_nxt = {a_r[3:0], a_r[MW-1:4]};
          carry_nxt = alu_res.cout;
          cnt_nxt = DW'(cnt_r + 1'b1);
          if (cnt_r == DW'(D - 1)) begin
            if (alu_res.cout) ovf_nxt = 1'b1;
            carry_nxt = 1'b0;
            cnt_nxt = '0;
            rep_nxt = rep_r - 4'd1;
          end
        end
      end
      // Divide: bring down the next dividend digit into the remainder.
      sdau_pkg::ST_DIVS: begin
        rem_nxt = {rem_r[MW-1:0], a_r[MW-1:MW-4]};
        a_nxt = {a_r[MW-5:0], 4'd0};
        rep_nxt = 4'd0;
        cnt_nxt = '0;
        carry_nxt = 1'b0;
        state_nxt = sdau_pkg::ST_DIVQ;
      end
      // Trial subtract remainder - divisor digit-serially; keep if no borrow.
      sdau_pkg::ST_DIVQ: begin
        alu_op.sub = 1'b1;
        alu_op.a = rem_r[3:0];
        alu_op.b = (cnt_r == DW'(D)) ? 4'd0 : b_r[3:0];
        alu_op.cin = carry_r;
        rem_nxt = {rem_r[3:0], rem_r[MW+3:4]};
        tmp_nxt = {alu_res.d, tmp_r[MW+3:4]};
        if (cnt_r != DW'(D)) b_nxt = {b_r[3:0], b_r[MW-1:4]};
        carry_nxt = alu_res.cout;
        cnt_nxt = DW'(cnt_r + 1'b1);
        if (cnt_r == DW'(D)) begin
          cnt_nxt = '0;
          carry_nxt = 1'b0;
          if (!alu_res.cout) begin
            rem_nxt = {alu_res.d, tmp_r[MW+3:4]};
            rep_nxt = rep_r + 4'd1;
          end else begin
            q_nxt = {q_r[MW-5:0], rep_r};
            dig_nxt = DW'(dig_r + 1'b1);
            if (dig_r == DW'(D - 1)) state_nxt = sdau_pkg::ST_DONE;
            else state_nxt = sdau_pkg::ST_DIVS;
          end
        end
      end
      sdau_pkg::ST_DONE: begin
        done_nxt = 1'b1;
        res_nxt = '0; rneg_nxt = 1'b0; rcmp_nxt = sdau_pkg::CMP_EQ;
        rdz_nxt = 1'b0; rovf_nxt = 1'b0;
        case (op_r)
          sdau_pkg::OP_ADD, sdau_pkg::OP_SUB: begin
            res_nxt = acc_r;
            rneg_nxt = (na_r == nb_r) ? na_r : (big_a ? na_r : nb_r);
            rovf_nxt = ovf_r;
          end
          sdau_pkg::OP_MUL: begin
            res_nxt = acc_r; rneg_nxt = na_r != nb_r; rovf_nxt = ovf_r;
          end
          sdau_pkg::OP_DIV: begin
            rdz_nxt = dz_r;
            if (!dz_r) begin
              res_nxt = q_r; rneg_nxt = na_r != nb_r;
            end
          end
          sdau_pkg::OP_CMP: begin
            if (na_r != nb_r) rcmp_nxt = na_r ? sdau_pkg::CMP_BGT : sdau_pkg::CMP_AGT;
            else if (mcmp_r == sdau_pkg::CMP_EQ) rcmp_nxt = sdau_pkg::CMP_EQ;
            else if ((mcmp_r == sdau_pkg::CMP_AGT) != na_r) rcmp_nxt = sdau_pkg::CMP_AGT;
            else rcmp_nxt = sdau_pkg::CMP_BGT;
          end
          default: ;
        endcase
        if (res_nxt == '0) rneg_nxt = 1'b0;
        state_nxt = sdau_pkg::ST_IDLE;
      end
      default: state_nxt = sdau_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdau_pkg::ST_IDLE;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r <= done_nxt;
    end
    a_r <= a_nxt; b_r <= b_nxt; acc_r <= acc_nxt; q_r <= q_nxt;
    rem_r <= rem_nxt; tmp_r <= tmp_nxt;
    op_r <= op_nxt; na_r <= na_nxt; nb_r <= nb_nxt;
    carry_r <= carry_nxt; mcmp_r <= mcmp_nxt; cnt_r <= cnt_nxt; dig_r <= dig_nxt;
    rep_r <= rep_nxt; ovf_r <= ovf_nxt; dz_r <= dz_nxt;
    res_r <= res_nxt; rneg_r <= rneg_nxt; rcmp_r <= rcmp_nxt;
    rdz_r <= rdz_nxt; rovf_r <= rovf_nxt;
  end
endmodule

### src/sdau_checker.sv
// Port-level checker for the signed decimal arithmetic unit, with its bind.
module sdau_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [63:0] out_result_digits,
  input logic        out_result_negative,
  input logic [1:0]  out_compare_result,
  input logic        out_divide_by_zero,
  input logic        out_overflow
);
  a_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !(out_result_negative && out_result_digits == 64'd0))
    else $error("negative zero result");
  a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("done held two cycles");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted transaction without busy");
  a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (done && out_divide_by_zero) |-> (out_result_digits == 64'd0 && !out_overflow
      && out_compare_result == 2'd0)) else $error("divide by zero result not clean");
endmodule

bind signed_decimal_arithmetic_unit sdau_checker u_sdau_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
  .out_result_digits(out_result_digits), .out_result_negative(out_result_negative),
  .out_compare_result(out_compare_result), .out_divide_by_zero(out_divide_by_zero),
  .out_overflow(out_overflow)
);
